>>> hdl/vfjb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vfjb_pkg;

  localparam int JB_QUEUE_DEPTH       = 16;
  localparam int JB_SAMPLES_PER_FRAME = 120;
  localparam logic [31:0] JB_FRAME_MAGIC = 32'h3057_4B54;

  localparam int JB_LISTEN_RESET  = 1;
  localparam int JB_PREBUF_RESET  = 4;
  localparam int JB_REG_W         = 5;

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_PULL   = 2'd2;

  localparam logic REG_LISTEN = 1'b0;
  localparam logic REG_PREBUF = 1'b1;

  typedef enum logic [2:0] {
    HS_NONE    = 3'd0,
    HS_BAD     = 3'd1,
    HS_OTHER   = 3'd2,
    HS_QUEUED  = 3'd3,
    HS_DROPPED = 3'd4
  } hdr_status_e;

  typedef struct packed {
    logic [31:0] other_channel;
    logic [31:0] dropped;
    logic [31:0] lost;
    logic [31:0] received;
  } jb_counts_t;

endpackage
`default_nettype wire

>>> hdl/vfjb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module vfjb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/vfjb_rx.sv
`timescale 1ns / 1ps
`default_nettype none
module vfjb_rx
  import vfjb_pkg::*;
#(
  parameter int QUEUE_DEPTH       = JB_QUEUE_DEPTH,
  parameter int SAMPLES_PER_FRAME = JB_SAMPLES_PER_FRAME,
  localparam int AW = $clog2(QUEUE_DEPTH * SAMPLES_PER_FRAME)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              header_i,
  input  wire logic              sample_i,
  input  wire logic [7:0]        packet_bytes_i,
  input  wire logic [31:0]       magic_word_i,
  input  wire logic [15:0]       sequence_req_i,
  input  wire logic [7:0]        channel_id_i,
  input  wire logic [7:0]        packet_flags_i,
  input  wire logic [15:0]       sample_in_i,
  input  wire logic [JB_REG_W-1:0] listen_i,
  input  wire logic              queue_full_i,
  output hdr_status_e            status_o,
  output logic                   gap_o,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [15:0]            wr_data_o,
  output logic                   frame_done_o,
  output jb_counts_t             counts_o
);

  localparam int IW = $clog2(SAMPLES_PER_FRAME);
  localparam logic [31:0] FrameBytes = 32'(8 + 2 * SAMPLES_PER_FRAME);
  localparam logic [AW-1:0] LastBase = AW'((QUEUE_DEPTH - 1) * SAMPLES_PER_FRAME);
  localparam logic [AW-1:0] BaseStep = AW'(SAMPLES_PER_FRAME);
  localparam logic [IW-1:0] LastIdx  = IW'(SAMPLES_PER_FRAME - 1);

  logic          capturing_q, capturing_d;
  logic [IW-1:0] fill_q, fill_d;
  logic [AW-1:0] wbase_q, wbase_d;
  logic [15:0]   prev_seq_q, prev_seq_d;
  jb_counts_t    counts_q, counts_d;

  logic hdr_ok, chan_ok, seq_gap;

  assign hdr_ok  = ({24'd0, packet_bytes_i} == FrameBytes) && (magic_word_i == JB_FRAME_MAGIC);
  assign chan_ok = ({3'd0, listen_i} == channel_id_i);
  assign seq_gap = !packet_flags_i[0] && (sequence_req_i != (prev_seq_q + 16'd1));

  always_comb begin
    capturing_d  = capturing_q;
    fill_d       = fill_q;
    wbase_d      = wbase_q;
    prev_seq_d   = prev_seq_q;
    counts_d     = counts_q;
    status_o     = HS_NONE;
    gap_o        = 1'b0;
    wr_en_o      = 1'b0;
    frame_done_o = 1'b0;
    if (header_i) begin
      if (!hdr_ok) begin
        status_o    = HS_BAD;
        capturing_d = 1'b0;
      end else if (!chan_ok) begin
        status_o               = HS_OTHER;
        capturing_d            = 1'b0;
        counts_d.other_channel = counts_q.other_channel + 32'd1;
      end else begin
        if (seq_gap) begin
          gap_o         = 1'b1;
          counts_d.lost = counts_q.lost + 32'd1;
        end
        prev_seq_d        = sequence_req_i;
        counts_d.received = counts_q.received + 32'd1;
        if (queue_full_i) begin
          status_o         = HS_DROPPED;
          capturing_d      = 1'b0;
          counts_d.dropped = counts_q.dropped + 32'd1;
        end else begin
          status_o    = HS_QUEUED;
          capturing_d = 1'b1;
          fill_d      = '0;
        end
      end
    end else if (sample_i && capturing_q) begin
      wr_en_o = 1'b1;
      if (fill_q == LastIdx) begin
        fill_d       = '0;
        capturing_d  = 1'b0;
        frame_done_o = 1'b1;
        wbase_d      = (wbase_q == LastBase) ? '0 : wbase_q + BaseStep;
      end else begin
        fill_d = fill_q + IW'(1);
      end
    end
  end

  assign wr_addr_o = wbase_q + AW'(fill_q);
  assign wr_data_o = sample_in_i;
  assign counts_o  = counts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      fill_q      <= '0;
      wbase_q     <= '0;
      prev_seq_q  <= '0;
      counts_q    <= '0;
    end else begin
      capturing_q <= capturing_d;
      fill_q      <= fill_d;
      wbase_q     <= wbase_d;
      prev_seq_q  <= prev_seq_d;
      counts_q    <= counts_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/vfjb_play.sv
`timescale 1ns / 1ps
`default_nettype none
module vfjb_play
  import vfjb_pkg::*;
#(
  parameter int QUEUE_DEPTH       = JB_QUEUE_DEPTH,
  parameter int SAMPLES_PER_FRAME = JB_SAMPLES_PER_FRAME,
  localparam int AW = $clog2(QUEUE_DEPTH * SAMPLES_PER_FRAME),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pull_i,
  input  wire logic                frame_done_i,
  input  wire logic [JB_REG_W-1:0] prebuf_i,
  output logic                     rd_en_o,
  output logic [AW-1:0]            rd_addr_o,
  output logic [CW-1:0]            queued_o,
  output logic                     queue_full_o
);

  localparam int IW = $clog2(SAMPLES_PER_FRAME);
  localparam logic [AW-1:0] LastBase = AW'((QUEUE_DEPTH - 1) * SAMPLES_PER_FRAME);
  localparam logic [AW-1:0] BaseStep = AW'(SAMPLES_PER_FRAME);
  localparam logic [IW-1:0] LastIdx  = IW'(SAMPLES_PER_FRAME - 1);

  logic          playing_q, playing_d;
  logic          phase_q, phase_d;
  logic [IW-1:0] play_q, play_d;
  logic [AW-1:0] rbase_q, rbase_d;
  logic [CW-1:0] queued_q, queued_d;

  logic play_now;

  assign play_now = (playing_q || (8'(queued_q) >= 8'(prebuf_i))) && (queued_q != '0);

  always_comb begin
    playing_d = playing_q;
    phase_d   = phase_q;
    play_d    = play_q;
    rbase_d   = rbase_q;
    queued_d  = queued_q;
    rd_en_o   = 1'b0;
    if (frame_done_i) begin
      queued_d = queued_q + CW'(1);
    end
    if (pull_i) begin
      playing_d = play_now;
      if (play_now) begin
        rd_en_o = 1'b1;
        phase_d = !phase_q;
        if (phase_q) begin
          if (play_q == LastIdx) begin
            play_d   = '0;
            rbase_d  = (rbase_q == LastBase) ? '0 : rbase_q + BaseStep;
            queued_d = queued_q - CW'(1);
          end else begin
            play_d = play_q + IW'(1);
          end
        end
      end
    end
  end

  assign rd_addr_o    = rbase_q + AW'(play_q);
  assign queued_o     = queued_q;
  assign queue_full_o = (queued_q == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      phase_q   <= 1'b0;
      play_q    <= '0;
      rbase_q   <= '0;
      queued_q  <= '0;
    end else begin
      playing_q <= playing_d;
      phase_q   <= phase_d;
      play_q    <= play_d;
      rbase_q   <= rbase_d;
      queued_q  <= queued_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/voice_frame_jitter_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Transfer                       Contents
// s_axis     in   tvalid & tready                one input word, action in tuser
// m_axis     out  tvalid & tready                one result word per input word
// cfg        in   cfg_we_i                       index 0 listen channel, 1 prebuffer
//
// Headers, samples and idle pulls are registered straight into the output; a playing pull
// waits on the registered read of the frame store, and no word is taken while it is pending.
// Reset clears all control state and counters; the frame store is not cleared.
// A result waits in the output register; the next word is taken as it leaves.
module voice_frame_jitter_buffer_core
  import vfjb_pkg::*;
#(
  parameter int QUEUE_DEPTH       = JB_QUEUE_DEPTH,
  parameter int SAMPLES_PER_FRAME = JB_SAMPLES_PER_FRAME
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // bytes[7:0] magic[39:8] sequence[55:40] channel[63:56] flags[71:64] sample[87:72]
  input  wire logic [87:0]         s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status[2:0] gap[3] sample[19:4] valid[20] frames[25:21] received[57:26]
  // lost[89:58] dropped[121:90] other_channel[153:122]
  output logic [159:0]             m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [JB_REG_W-1:0] cfg_data_i
);

  localparam int Depth = QUEUE_DEPTH * SAMPLES_PER_FRAME;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);

  logic [JB_REG_W-1:0] listen_q, prebuf_q;

  logic        accept, header, sample, pull;
  hdr_status_e status;
  logic        gap;
  logic        wr_en, rd_en, frame_done, queue_full;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0] wr_data, rd_data;
  logic [CW-1:0] queued;
  jb_counts_t  counts;

  logic        rd_pend_q;
  logic        out_vld_q;
  hdr_status_e status_q;
  logic        gap_q, svalid_q;
  logic [15:0] sample_q;

  assign s_axis_tready = !rd_pend_q && (!out_vld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign header        = accept && (s_axis_tuser == ACT_HEADER);
  assign sample        = accept && (s_axis_tuser == ACT_SAMPLE);
  assign pull          = accept && (s_axis_tuser == ACT_PULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= JB_REG_W'(JB_LISTEN_RESET);
      prebuf_q <= JB_REG_W'(JB_PREBUF_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LISTEN: listen_q <= cfg_data_i;
        REG_PREBUF: prebuf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vfjb_rx #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .header_i      (header),
    .sample_i      (sample),
    .packet_bytes_i(s_axis_tdata[7:0]),
    .magic_word_i  (s_axis_tdata[39:8]),
    .sequence_req_i(s_axis_tdata[55:40]),
    .channel_id_i  (s_axis_tdata[63:56]),
    .packet_flags_i(s_axis_tdata[71:64]),
    .sample_in_i   (s_axis_tdata[87:72]),
    .listen_i      (listen_q),
    .queue_full_i  (queue_full),
    .status_o      (status),
    .gap_o         (gap),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .frame_done_o  (frame_done),
    .counts_o      (counts)
  );

  vfjb_play #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_play (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pull_i      (pull),
    .frame_done_i(frame_done),
    .prebuf_i    (prebuf_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .queued_o    (queued),
    .queue_full_o(queue_full)
  );

  vfjb_ram #(
    .WIDTH(16),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
      if ((accept && !rd_en) || rd_pend_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload: counters and fill level are read live, they hold until the next word
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      status_q <= HS_NONE;
      gap_q    <= 1'b0;
      sample_q <= rd_data;
      svalid_q <= 1'b1;
    end else if (accept && !rd_en) begin
      status_q <= status;
      gap_q    <= gap;
      sample_q <= '0;
      svalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, counts.other_channel, counts.dropped, counts.lost,
                          counts.received, 5'(queued), svalid_q, sample_q, gap_q,
                          status_q};

endmodule
`default_nettype wire
